[rtl/qle_pkg.sv]
// Package for the tabular Q-learning engine: sizes, register indexes,
// reset values and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package qle_pkg;

  localparam int NUM_STATES  = 256;
  localparam int NUM_ACTIONS = 4;
  localparam int VALUE_WIDTH = 24;

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int ACT_W   = $clog2(NUM_ACTIONS);
  localparam int ADDR_W  = STATE_W + ACT_W;
  localparam int Q_DEPTH = NUM_STATES * NUM_ACTIONS;

  localparam int REWARD_W = 10;
  localparam int DRAW_W   = 16;
  localparam int PICK_W   = 8;
  localparam int RATE_W   = 9;
  localparam int EPS_W    = 17;

  // stream widths
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE_CHANCE = 2'd2;

  localparam logic [RATE_W-1:0] LEARN_RATE_RST     = 9'd26;
  localparam logic [RATE_W-1:0] DISCOUNT_RST       = 9'd102;
  localparam logic [EPS_W-1:0]  EXPLORE_CHANCE_RST = 17'd6554;
  localparam logic [RATE_W-1:0] RATE_MAX           = 9'd256;
  localparam logic [EPS_W-1:0]  EPS_MAX            = 17'd65536;

  // table read selector: 0..NUM_ACTIONS-1 read the row, RD_CUR reads Q[s][a]
  localparam int RD_SEL_W = 3;
  localparam logic [RD_SEL_W-1:0] RD_CUR      = 3'd4;
  localparam logic [RD_SEL_W-1:0] RD_ROW_LAST = 3'd3;

  typedef logic signed [VALUE_WIDTH-1:0] q_t;

  typedef struct packed {
    logic                load_item;
    logic                clr_we;
    logic [ADDR_W-1:0]   clr_addr;
    logic                rd_en;
    logic [RD_SEL_W-1:0] rd_sel;
    logic                max_en;
    logic                pick_en;
    logic                mul1_en;
    logic                sum_en;
    logic                mul2_en;
    logic                fin_en;
    logic                out_load;
    logic                wr_en;
  } qle_cmd_t;

  typedef struct packed {
    logic kind_upd;
    logic out_free;
  } qle_sts_t;

endpackage

[rtl/tabular_q_learning_engine_core.sv]
// Top level of the tabular Q-learning engine (epsilon-greedy decide, Q update).
// Depends on qle_pkg, qle_ctrl, qle_dp (which holds qle_ram).
`timescale 1ns / 1ps

// Q-learning engine with a 256-state x 4-action table of signed values with
// 8 fraction bits. After reset the table is zeroed by a clearing pass (one
// entry per cycle) during which s_axis_tready stays low; config writes are
// taken throughout. One input beat gives one output beat. A decide beat runs
// four table reads of the row, a read wait, the max/tie stage, the pick stage
// and the output load; an update beat runs five reads (the row of next_state
// plus Q[s][a]), then max, two registered multiplies with a sum between,
// rounding and saturation, and a write-back with the output load. Its length
// is set by the single read port of the table RAM and the multiply chain. Items
// are worked one at a time; a new beat is accepted while the previous result
// still waits on the master side.
// Registers: 0 learn_rate (alpha/256), 1 discount (gamma/256), 2 explore_chance
// (epsilon/65536); over-range values are clamped (rates use data bits 8:0); index 3 is ignored.

module tabular_q_learning_engine_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata, low bit up: state_index[8], action_taken[2], next_state[8],
  // reward[10], random_draw[16], random_action[2], random_pick[8], zero pad[2]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [qle_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tuser,   // kind: 0 decide, 1 update
  // tdata, low bit up: chosen_action[2], q_value[24], zero pad[6]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [qle_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic [qle_pkg::M_TUSER_W-1:0]   m_axis_tuser,   // explored, saturated
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [qle_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [qle_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import qle_pkg::*;

  qle_cmd_t cmd;
  qle_sts_t sts;

  // registers are always writable; the block only expects writes when idle
  assign cfg_ready_o = 1'b1;

  qle_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  qle_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

endmodule

[rtl/qle_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module qle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/qle_dp.sv]
// Datapath of the Q-learning engine: item and config registers, Q table RAM,
// greedy pick, update arithmetic and output register. Depends on qle_pkg, qle_ram.
`timescale 1ns / 1ps

module qle_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qle_pkg::qle_cmd_t            cmd_i,
  output qle_pkg::qle_sts_t            sts_o,
  input  logic [qle_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [qle_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic [qle_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input  logic                         cfg_valid_i,
  input  logic [qle_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [qle_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import qle_pkg::*;

  localparam int T_W   = 35;
  localparam int P1_W  = RATE_W + 1 + VALUE_WIDTH;
  localparam int P2_W  = RATE_W + 1 + T_W;
  localparam int SUM_W = VALUE_WIDTH + 6;

  // config registers
  logic [RATE_W-1:0] lr_q, disc_q;
  logic [EPS_W-1:0]  eps_q;
  logic [RATE_W-1:0] cfg_rate_w;

  assign cfg_rate_w = (cfg_data_i[RATE_W-1:0] > RATE_MAX) ? RATE_MAX : cfg_data_i[RATE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q   <= LEARN_RATE_RST;
      disc_q <= DISCOUNT_RST;
      eps_q  <= EXPLORE_CHANCE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LEARN_RATE:     lr_q   <= cfg_rate_w;
        CFG_DISCOUNT:       disc_q <= cfg_rate_w;
        CFG_EXPLORE_CHANCE: eps_q  <= (cfg_data_i > EPS_MAX) ? EPS_MAX : cfg_data_i;
        default:            ;
      endcase
    end
  end

  // item fields
  logic                       it_kind_q;
  logic [STATE_W-1:0]         it_s_q, it_ns_q;
  logic [ACT_W-1:0]           it_a_q, it_ra_q;
  logic signed [REWARD_W-1:0] it_rew_q;
  logic [DRAW_W-1:0]          it_draw_q;
  logic [PICK_W-1:0]          it_pick_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      it_kind_q <= s_axis_tuser;
      it_s_q    <= s_axis_tdata[7:0];
      it_a_q    <= s_axis_tdata[9:8];
      it_ns_q   <= s_axis_tdata[17:10];
      it_rew_q  <= $signed(s_axis_tdata[27:18]);
      it_draw_q <= s_axis_tdata[43:28];
      it_ra_q   <= s_axis_tdata[45:44];
      it_pick_q <= s_axis_tdata[53:46];
    end
  end

  // Q table
  logic [ADDR_W-1:0]      raddr, waddr;
  logic [VALUE_WIDTH-1:0] rdata, wdata;
  logic [STATE_W-1:0]     row_state;
  q_t                     res_val_q;

  assign row_state = it_kind_q ? it_ns_q : it_s_q;
  assign raddr = (cmd_i.rd_sel == RD_CUR) ? {it_s_q, it_a_q}
                                          : {row_state, cmd_i.rd_sel[ACT_W-1:0]};
  assign waddr = cmd_i.clr_we ? cmd_i.clr_addr : {it_s_q, it_a_q};
  assign wdata = cmd_i.clr_we ? '0 : res_val_q;

  qle_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (Q_DEPTH)
  ) u_qtab (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_we | cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // read data comes from the RAM in the cycle after the request; rd_pend_q marks it
  logic                rd_pend_q;
  logic [RD_SEL_W-1:0] rd_pend_sel_q;
  q_t                  row_q [NUM_ACTIONS];
  q_t                  q_cur_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pend_sel_q <= cmd_i.rd_sel;
    if (rd_pend_q) begin
      if (rd_pend_sel_q == RD_CUR) begin
        q_cur_q <= $signed(rdata);
      end else begin
        row_q[rd_pend_sel_q[ACT_W-1:0]] <= $signed(rdata);
      end
    end
  end

  // row maximum and tie count
  q_t         max_d, max_q;
  logic [2:0] ties_d, ties_q;

  always_comb begin
    max_d  = row_q[0];
    ties_d = '0;
    for (int i = 1; i < NUM_ACTIONS; i++) begin
      if (row_q[i] > max_d) max_d = row_q[i];
    end
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (row_q[i] == max_d) ties_d = ties_d + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.max_en) begin
      max_q  <= max_d;
      ties_q <= ties_d;
    end
  end

  // pick mod ties, ties in 1..4; divide by three through x*171 >> 9
  function automatic logic [ACT_W-1:0] pick_mod(input logic [PICK_W-1:0] pick,
                                                input logic [2:0] ties);
    logic [15:0] prod;
    logic [9:0]  q3;
    logic [9:0]  rem;
    begin
      prod = 16'(pick) * 16'd171;
      q3   = 10'(prod[15:9]) * 10'd3;
      rem  = {2'b00, pick} - q3;
      case (ties)
        3'd1:    pick_mod = '0;
        3'd2:    pick_mod = {1'b0, pick[0]};
        3'd3:    pick_mod = rem[ACT_W-1:0];
        default: pick_mod = pick[ACT_W-1:0];
      endcase
    end
  endfunction

  logic             explore_w;
  logic [ACT_W-1:0] k_w, cnt, gact, sel_act;
  logic             found;

  assign explore_w = {1'b0, it_draw_q} < eps_q;
  assign k_w       = pick_mod(it_pick_q, ties_q);

  always_comb begin
    cnt   = k_w;
    found = 1'b0;
    gact  = '0;
    for (int i = 0; i < NUM_ACTIONS; i++) begin
      if (row_q[i] == max_q && !found) begin
        if (cnt == '0) begin
          gact  = ACT_W'(i);
          found = 1'b1;
        end else begin
          cnt = cnt - 1'b1;
        end
      end
    end
    sel_act = explore_w ? it_ra_q : gact;
  end

  // update: t = r*2^16 + gamma*m - q*2^8, inc = floor((alpha*t + 2^15) / 2^16)
  logic signed [P1_W-1:0]  p1_q;
  logic signed [T_W-1:0]   t_q;
  logic signed [P2_W-1:0]  p2_q;
  logic signed [SUM_W-1:0] sum_w;
  logic                    sat_hi, sat_lo;

  assign sum_w  = SUM_W'(q_cur_q) + SUM_W'($signed(p2_q[P2_W-1:16]));
  assign sat_hi = sum_w > SUM_W'($signed({1'b0, {(VALUE_WIDTH-1){1'b1}}}));
  assign sat_lo = sum_w < SUM_W'($signed({1'b1, {(VALUE_WIDTH-1){1'b0}}}));

  logic [ACT_W-1:0] res_act_q;
  logic             res_expl_q, res_sat_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1_en) begin
      p1_q <= $signed({1'b0, disc_q}) * max_q;
    end
    if (cmd_i.sum_en) begin
      t_q <= T_W'($signed({it_rew_q, 16'd0})) + T_W'(p1_q)
             - T_W'($signed({q_cur_q, 8'd0}));
    end
    if (cmd_i.mul2_en) begin
      p2_q <= $signed({1'b0, lr_q}) * t_q + P2_W'(32768);
    end
    if (cmd_i.pick_en) begin
      res_val_q  <= row_q[sel_act];
      res_act_q  <= sel_act;
      res_expl_q <= explore_w;
      res_sat_q  <= 1'b0;
    end else if (cmd_i.fin_en) begin
      res_act_q  <= it_a_q;
      res_expl_q <= 1'b0;
      res_sat_q  <= sat_hi | sat_lo;
      if (sat_hi)      res_val_q <= $signed({1'b0, {(VALUE_WIDTH-1){1'b1}}});
      else if (sat_lo) res_val_q <= $signed({1'b1, {(VALUE_WIDTH-1){1'b0}}});
      else             res_val_q <= sum_w[VALUE_WIDTH-1:0];
    end
  end

  // output register
  logic                  m_valid_q;
  logic [M_TDATA_W-1:0]  m_data_q;
  logic [M_TUSER_W-1:0]  m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_data_q <= {{(M_TDATA_W-VALUE_WIDTH-ACT_W){1'b0}}, res_val_q, res_act_q};
      m_user_q <= {res_sat_q, res_expl_q};
    end
  end

  assign m_axis_tvalid  = m_valid_q;
  assign m_axis_tdata   = m_data_q;
  assign m_axis_tuser   = m_user_q;
  assign sts_o.kind_upd = it_kind_q;
  assign sts_o.out_free = !m_valid_q || m_axis_tready;

endmodule

[rtl/qle_ctrl.sv]
// Controller of the Q-learning engine: table clearing pass after reset and
// the per-item step sequence. Depends on qle_pkg.
`timescale 1ns / 1ps

module qle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  qle_pkg::qle_sts_t sts_i,
  output qle_pkg::qle_cmd_t cmd_o
);

  import qle_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_WAIT  = 4'd3;
  localparam logic [3:0] ST_MAX   = 4'd4;
  localparam logic [3:0] ST_PICK  = 4'd5;
  localparam logic [3:0] ST_MUL1  = 4'd6;
  localparam logic [3:0] ST_SUM   = 4'd7;
  localparam logic [3:0] ST_MUL2  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0]          state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic [RD_SEL_W-1:0] rd_cnt_q, rd_cnt_d;
  logic [RD_SEL_W-1:0] rd_last;

  assign rd_last = sts_i.kind_upd ? RD_CUR : RD_ROW_LAST;

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    rd_cnt_d  = rd_cnt_q;
    cmd_o     = '0;
    cmd_o.clr_addr = clr_cnt_q;
    cmd_o.rd_sel   = rd_cnt_q;
    s_axis_tready  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_cnt_d    = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(Q_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready   = 1'b1;
        cmd_o.load_item = s_axis_tvalid;
        rd_cnt_d        = '0;
        if (s_axis_tvalid) state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        rd_cnt_d    = rd_cnt_q + 1'b1;
        if (rd_cnt_q == rd_last) state_d = ST_WAIT;
      end
      ST_WAIT: state_d = ST_MAX;
      ST_MAX: begin
        cmd_o.max_en = 1'b1;
        state_d = sts_i.kind_upd ? ST_MUL1 : ST_PICK;
      end
      ST_PICK: begin
        cmd_o.pick_en = 1'b1;
        state_d = ST_OUT;
      end
      ST_MUL1: begin
        cmd_o.mul1_en = 1'b1;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2_en = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin_en = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.wr_en    = sts_i.kind_upd;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      rd_cnt_q  <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      rd_cnt_q  <= rd_cnt_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded over an untaken beat");

  a_accept_starts_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_READ && rd_cnt_q == '0))
    else $error("accepted beat did not start the table reads");

  a_write_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (sts_i.kind_upd && !cmd_o.clr_we && !cmd_o.rd_en))
    else $error("table write outside an update write-back");

  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (rd_cnt_q <= rd_last))
    else $error("read counter ran past the last table read");

endmodule

[tb/tb_tabular_q_learning_engine_core.sv]
// Self-checking bench for tabular_q_learning_engine_core: directed and random decide/update
// beats against an in-bench Q table predictor, with random stalls and a long output hold-off.
// Depends on qle_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_tabular_q_learning_engine_core;
  import qle_pkg::*;

  localparam logic KIND_DECIDE = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;
  localparam int   DRAIN_CYCLES = 20;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum int {REW_MIXED, REW_HIGH, REW_LOW} reward_mode_e;

  typedef struct {
    logic                       kind;
    logic [STATE_W-1:0]         state;
    logic [ACT_W-1:0]           act;
    logic [STATE_W-1:0]         nxt;
    logic signed [REWARD_W-1:0] reward;
    logic [DRAW_W-1:0]          draw;
    logic [ACT_W-1:0]           ract;
    logic [PICK_W-1:0]          pick;
  } step_t;

  typedef struct {
    logic [ACT_W-1:0]       action;
    logic                   explored;
    logic [VALUE_WIDTH-1:0] q;
    logic                   sat;
  } outcome_t;

  // Mirror of the Q table and registers; predicts one outcome per accepted beat.
  class q_scoreboard;
    longint   q_val [Q_DEPTH];
    longint   alpha, gamma, epsilon;
    outcome_t expected [$];
    int       errors;

    function new();
      foreach (q_val[i]) q_val[i] = 0;
      alpha   = LEARN_RATE_RST;
      gamma   = DISCOUNT_RST;
      epsilon = EXPLORE_CHANCE_RST;
      errors  = 0;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      longint v;
      case (idx)
        CFG_LEARN_RATE: begin
          v = data[RATE_W-1:0];
          alpha = (v > RATE_MAX) ? RATE_MAX : v;
        end
        CFG_DISCOUNT: begin
          v = data[RATE_W-1:0];
          gamma = (v > RATE_MAX) ? RATE_MAX : v;
        end
        CFG_EXPLORE_CHANCE: begin
          v = data;
          epsilon = (v > EPS_MAX) ? EPS_MAX : v;
        end
        default: ;  // unused index, no effect
      endcase
    endfunction

    function longint row_max(int s);
      longint m;
      m = q_val[s*NUM_ACTIONS];
      for (int i = 1; i < NUM_ACTIONS; i++)
        if (q_val[s*NUM_ACTIONS+i] > m) m = q_val[s*NUM_ACTIONS+i];
      return m;
    endfunction

    function void note_item(step_t it);
      outcome_t o;
      longint   m, q, t, inc, v;
      longint   qmax, qmin;
      int       ties, k, s;
      qmax = (longint'(1) <<< (VALUE_WIDTH-1)) - 1;
      qmin = -qmax - 1;
      s    = it.state;
      o.explored = 1'b0;
      o.sat      = 1'b0;
      if (it.kind == KIND_DECIDE) begin
        if (longint'(it.draw) < epsilon) begin
          o.action   = it.ract;
          o.explored = 1'b1;
        end else begin
          m    = row_max(s);
          ties = 0;
          for (int i = 0; i < NUM_ACTIONS; i++)
            if (q_val[s*NUM_ACTIONS+i] == m) ties++;
          k        = int'(it.pick) % ties;
          o.action = '0;
          for (int i = 0; i < NUM_ACTIONS; i++) begin
            if (q_val[s*NUM_ACTIONS+i] == m) begin
              if (k == 0) begin
                o.action = ACT_W'(i);
                break;
              end
              k--;
            end
          end
        end
        v = q_val[s*NUM_ACTIONS+o.action];
      end else begin
        q   = q_val[s*NUM_ACTIONS+it.act];
        m   = row_max(it.nxt);
        // 16 fraction bits, one rounding (half up) back to 8
        t   = longint'(it.reward) * 65536 + gamma * m - q * 256;
        inc = (alpha * t + 32768) >>> 16;
        v   = q + inc;
        if (v > qmax) begin
          v     = qmax;
          o.sat = 1'b1;
        end else if (v < qmin) begin
          v     = qmin;
          o.sat = 1'b1;
        end
        q_val[s*NUM_ACTIONS+it.act] = v;
        o.action = it.act;
      end
      o.q = v[VALUE_WIDTH-1:0];
      expected = {expected, o};
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
      outcome_t e;
      if (expected.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing outstanding, tdata %h", data));
        return;
      end
      e = expected.pop_front();
      if (data[ACT_W-1:0] !== e.action)
        report_mismatch($sformatf("chosen_action %0d, want %0d",
                                  data[ACT_W-1:0], e.action));
      if (data[ACT_W +: VALUE_WIDTH] !== e.q)
        report_mismatch($sformatf("q_value %h, want %h", data[ACT_W +: VALUE_WIDTH], e.q));
      if (user[0] !== e.explored)
        report_mismatch($sformatf("explored %b, want %b", user[0], e.explored));
      if (user[1] !== e.sat)
        report_mismatch($sformatf("saturated %b, want %b", user[1], e.sat));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  q_scoreboard sb = new();
  bit          quiet;       // no idling on either side
  int          hold_len;    // output hold-off request, in cycles

  tabular_q_learning_engine_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit: the timeout lies far beyond the slowest legal run, clearing pass included.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Both handshakes sampled on the edge, before any driver update lands.
  // Output checked first so a same-edge input never feeds its own check.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) begin : accept_in
        step_t it;
        it.state  = s_axis_tdata[7:0];
        it.act    = s_axis_tdata[9:8];
        it.nxt    = s_axis_tdata[17:10];
        it.reward = s_axis_tdata[27:18];
        it.draw   = s_axis_tdata[43:28];
        it.ract   = s_axis_tdata[45:44];
        it.pick   = s_axis_tdata[53:46];
        it.kind   = s_axis_tuser;
        sb.note_item(it);
      end
    end
  end

  // Output side: random stall bursts, plus the long hold-off when asked for.
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic step_t mk(logic kind, int s, int a, int ns, int rew, int draw,
                               int ract, int pick);
    step_t it;
    it.kind   = kind;
    it.state  = STATE_W'(s);
    it.act    = ACT_W'(a);
    it.nxt    = STATE_W'(ns);
    it.reward = REWARD_W'(rew);
    it.draw   = DRAW_W'(draw);
    it.ract   = ACT_W'(ract);
    it.pick   = PICK_W'(pick);
    return it;
  endfunction

  // Mostly the narrow pool so entries build up; now and then anywhere in the table.
  function automatic int pool_state(int lo, int hi);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, NUM_STATES-1)
                                       : $urandom_range(lo, hi);
  endfunction

  function automatic step_t gen_item(int lo, int hi, reward_mode_e rmode, int upd_pct);
    step_t  it;
    longint eps;
    eps       = sb.epsilon;
    it.kind   = ($urandom_range(0, 99) < upd_pct) ? KIND_UPDATE : KIND_DECIDE;
    it.state  = STATE_W'(pool_state(lo, hi));
    it.nxt    = STATE_W'(pool_state(lo, hi));
    it.act    = ACT_W'($urandom_range(0, NUM_ACTIONS-1));
    it.ract   = ACT_W'($urandom_range(0, NUM_ACTIONS-1));
    it.pick   = PICK_W'($urandom_range(0, 255));
    it.reward = REWARD_W'($urandom_range(0, 1023));
    case (rmode)
      REW_HIGH: if ($urandom_range(0, 7) != 0) it.reward = REWARD_W'(511);
      REW_LOW:  if ($urandom_range(0, 7) != 0) it.reward = REWARD_W'(-512);
      default: begin
        case ($urandom_range(0, 3))
          0:       it.reward = REWARD_W'(511);
          1:       it.reward = REWARD_W'(-512);
          default: ;
        endcase
      end
    endcase
    // draws around the explore threshold
    case ($urandom_range(0, 3))
      0:       it.draw = DRAW_W'((eps == 0) ? 0 : eps - 1);
      1:       it.draw = DRAW_W'((eps > 65535) ? 65535 : eps);
      default: it.draw = DRAW_W'($urandom_range(0, 65535));
    endcase
    return it;
  endfunction

  // Leaves tvalid high after the beat is taken; the caller decides what follows.
  task automatic send_item(step_t it);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {2'b00, it.pick, it.ract, it.draw, it.reward, it.nxt, it.act, it.state};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_TDATA_W'({$urandom, $urandom});
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Wait until every outstanding result is back, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_rates(int lr, int disc, int eps);
    write_reg(CFG_LEARN_RATE, CFG_DATA_W'(lr));
    write_reg(CFG_DISCOUNT, CFG_DATA_W'(disc));
    write_reg(CFG_EXPLORE_CHANCE, CFG_DATA_W'(eps));
  endtask

  task automatic run_phase(int n, int lo, int hi, reward_mode_e rmode, int upd_pct);
    for (int i = 0; i < n; i++) begin
      send_item(gen_item(lo, hi, rmode, upd_pct));
      sender_gap();
    end
    drain();
  endtask

  initial begin
    step_t directed [$];
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_DECIDE;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_LEARN_RATE;
    cfg_data_i    <= '0;
    quiet    = 1'b0;
    hold_len = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset register values: explore threshold either side, ties on the
    // cleared table, field extremes, single and double maxima after updates.
    directed = '{
      mk(KIND_DECIDE, 0,   0, 0,   0,    0,     3, 0),
      mk(KIND_DECIDE, 0,   0, 0,   0,    6553,  2, 0),
      mk(KIND_DECIDE, 0,   0, 0,   0,    6554,  1, 255),
      mk(KIND_DECIDE, 255, 3, 255, 511,  65535, 3, 0),
      mk(KIND_UPDATE, 255, 3, 255, 511,  0,     0, 0),
      mk(KIND_UPDATE, 255, 3, 255, 511,  65535, 3, 255),
      mk(KIND_DECIDE, 255, 0, 0,   0,    65535, 0, 7),
      mk(KIND_UPDATE, 0,   1, 255, -512, 0,     0, 0),
      mk(KIND_UPDATE, 0,   2, 0,   -1,   0,     0, 0),
      mk(KIND_DECIDE, 0,   0, 0,   0,    65535, 0, 1),
      mk(KIND_DECIDE, 0,   0, 0,   0,    65535, 0, 2),
      mk(KIND_UPDATE, 128, 0, 0,   0,    0,     0, 0),
      mk(KIND_UPDATE, 1,   2, 255, 0,    0,     0, 0),
      mk(KIND_DECIDE, 1,   0, 0,   0,    40000, 0, 200),
      mk(KIND_UPDATE, 255, 3, 255, -512, 65535, 3, 255),
      mk(KIND_DECIDE, 255, 3, 255, -512, 65535, 3, 255),
      mk(KIND_UPDATE, 0,   0, 0,   0,    0,     0, 0),
      mk(KIND_DECIDE, 0,   0, 0,   0,    0,     0, 0)
    };
    foreach (directed[i]) begin
      send_item(directed[i]);
      sender_gap();
    end
    drain();

    // Full alpha and gamma, no exploring: drive a small pool to positive saturation.
    // The output side is held off for a long stretch so the engine backs up.
    set_rates(RATE_MAX, RATE_MAX, 0);
    hold_len = 300;
    run_phase(250, 0, 1, REW_HIGH, 80);
    // mostly a single state pushed to negative saturation
    run_phase(300, 200, 200, REW_LOW, 90);

    // over-range writes clamp; epsilon at full scale always explores; unused index ignored
    set_rates(9'h1FF, 300, 17'h1FFFF);
    write_reg(CFG_IDX_UNUSED, 17'h0ABCD);
    run_phase(150, 0, 255, REW_MIXED, 50);

    // nothing learnt, almost always exploring
    set_rates(0, 0, 65535);
    run_phase(150, 0, 15, REW_MIXED, 50);

    set_rates(26, 102, 32768);
    run_phase(300, 0, 15, REW_MIXED, 60);

    // random settings, full cfg data width so masking is exercised too
    for (int p = 0; p < 3; p++) begin
      set_rates($urandom_range(0, 131071), $urandom_range(0, 131071),
                $urandom_range(0, 131071));
      write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom_range(0, 131071)));
      run_phase(150, 0, 31, REW_MIXED, 60);
    end

    // back to back, no idling either side
    set_rates($urandom_range(1, 256), $urandom_range(0, 256), $urandom_range(0, 65536));
    quiet = 1'b1;
    run_phase(200, 0, 7, REW_MIXED, 60);

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/qle_pkg.sv
rtl/qle_ram.sv
rtl/qle_dp.sv
rtl/qle_ctrl.sv
rtl/tabular_q_learning_engine_core.sv
tb/tb_tabular_q_learning_engine_core.sv
